// ===== hdl/fmcq_pkg.sv =====
// Shared constants, result codes and controller/datapath interface types.
package fmcq_pkg;

  localparam int DEPTH     = 16;
  localparam int TAG_BITS  = 16;
  localparam int TYPE_BITS = 3;
  localparam int IDX_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  typedef logic [1:0] status_code_t;

  localparam status_code_t ST_DONE    = 2'd0;
  localparam status_code_t ST_FULL    = 2'd1;
  localparam status_code_t ST_EMPTY   = 2'd2;
  localparam status_code_t ST_NOMATCH = 2'd3;

  localparam logic FUNC_ENQ  = 1'b0;
  localparam logic FUNC_TAKE = 1'b1;

  typedef struct packed {
    logic         latch_req;
    logic         wr_enq;
    logic         clr_idx;
    logic         inc_idx;
    logic         shift;
    logic         load_out;
    status_code_t out_status;
  } fmcq_cmd_t;

  typedef struct packed {
    logic                is_enq;
    logic                full;
    logic                empty;
    logic                type_match;
    logic                last_idx;
    logic [CNT_BITS-1:0] count;
  } fmcq_stat_t;

endpackage

// ===== hdl/fmcq_ctrl.sv =====
// Sequencer for enqueue and take requests and the output valid flag.
module fmcq_ctrl
  import fmcq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  fmcq_stat_t stat,
  output fmcq_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_SHIFT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_enq) begin
          if (out_free) begin
            cmd.load_out = 1'b1;
            if (stat.full) begin
              cmd.out_status = ST_FULL;
            end else begin
              cmd.wr_enq     = 1'b1;
              cmd.out_status = ST_DONE;
            end
            state_next = S_IDLE;
          end
        end else if (stat.empty) begin
          if (out_free) begin
            cmd.load_out   = 1'b1;
            cmd.out_status = ST_EMPTY;
            state_next     = S_IDLE;
          end
        end else begin
          cmd.clr_idx = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.type_match) begin
          // idx now points at the oldest hit
          state_next = S_SHIFT;
        end else if (stat.last_idx) begin
          if (out_free) begin
            cmd.load_out   = 1'b1;
            cmd.out_status = ST_NOMATCH;
            state_next     = S_IDLE;
          end
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      S_SHIFT: begin
        if (out_free) begin
          cmd.shift      = 1'b1;
          cmd.load_out   = 1'b1;
          cmd.out_status = ST_DONE;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/fmcq_dp.sv =====
// Slot registers, scan pointer, entry count and result register.
module fmcq_dp
  import fmcq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 func,
  input  logic [TAG_BITS-1:0]  item_tag,
  input  logic [TYPE_BITS-1:0] item_type,
  input  fmcq_cmd_t            cmd,
  output fmcq_stat_t           stat,
  output status_code_t         status,
  output logic [TAG_BITS-1:0]  taken_tag,
  output logic [CNT_BITS-1:0]  occupancy
);

  logic [TAG_BITS-1:0]  slot_tag  [DEPTH];
  logic [TYPE_BITS-1:0] slot_type [DEPTH];
  logic                 req_func;
  logic [TAG_BITS-1:0]  req_tag;
  logic [TYPE_BITS-1:0] req_type;
  logic [CNT_BITS-1:0]  count;
  logic [CNT_BITS-1:0]  count_next;
  logic [IDX_BITS-1:0]  idx;
  logic [IDX_BITS-1:0]  wr_idx;

  assign wr_idx = count[IDX_BITS-1:0];

  always_comb begin
    stat.is_enq     = (req_func == FUNC_ENQ);
    stat.full       = (count == CNT_BITS'(DEPTH));
    stat.empty      = (count == '0);
    stat.type_match = (slot_type[idx] == req_type);
    stat.last_idx   = ((CNT_BITS'(idx) + CNT_BITS'(1)) == count);
    stat.count      = count;
  end

  always_comb begin
    count_next = count;
    if (cmd.wr_enq) begin
      count_next = count + CNT_BITS'(1);
    end else if (cmd.shift) begin
      count_next = count - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_func <= func;
      req_tag  <= item_tag;
      req_type <= item_type;
    end
    if (cmd.clr_idx) begin
      idx <= '0;
    end else if (cmd.inc_idx) begin
      idx <= idx + IDX_BITS'(1);
    end
    if (cmd.load_out) begin
      status    <= cmd.out_status;
      taken_tag <= cmd.shift ? slot_tag[idx] : '0;
      occupancy <= count_next;
    end
  end

  // The hit slot and each slot above it take their younger neighbor at once.
  always_ff @(posedge clk) begin
    for (int k = 0; k < DEPTH - 1; k++) begin
      if (cmd.shift && (IDX_BITS'(k) >= idx)) begin
        slot_tag[k]  <= slot_tag[k+1];
        slot_type[k] <= slot_type[k+1];
      end else if (cmd.wr_enq && (IDX_BITS'(k) == wr_idx)) begin
        slot_tag[k]  <= req_tag;
        slot_type[k] <= req_type;
      end
    end
    if (cmd.wr_enq && (wr_idx == IDX_BITS'(DEPTH - 1))) begin
      slot_tag[DEPTH-1]  <= req_tag;
      slot_type[DEPTH-1] <= req_type;
    end
  end

endmodule

// ===== hdl/first_match_collapsing_queue_top.sv =====
// Ordered tagged queue with removal of the oldest entry of a wanted type.
//
// Input channel (in_valid / in_stall): func selects enqueue (0) or take (1);
// item_tag and item_type carry the entry, or for take the wanted type.
// Output channel (out_valid / out_stall): one result per request with status
// (done, full, empty, no match), the removed tag on a successful take (else
// zero) and the number of entries held after the request.
// A request is accepted only while the sequencer is idle. An enqueue or an
// empty take needs no scan; any other take walks the scan pointer one slot
// per cycle from the oldest entry, then the younger slots collapse onto the
// hit all together.
// The result sits in an output register; a new request may be accepted while
// it waits. If the receiver stalls, the finished result holds steady and the
// next request waits at its final step until the register frees up.
// Reset empties the queue and drops any pending result; slot contents are not
// cleared, since only slots below the entry count are ever read.
module first_match_collapsing_queue_top
  import fmcq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 func,
  input  logic [TAG_BITS-1:0]  item_tag,
  input  logic [TYPE_BITS-1:0] item_type,
  output logic                 out_valid,
  input  logic                 out_stall,
  output status_code_t         status,
  output logic [TAG_BITS-1:0]  taken_tag,
  output logic [CNT_BITS-1:0]  occupancy
);

  fmcq_cmd_t  cmd;
  fmcq_stat_t stat;

  fmcq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  fmcq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .func      (func),
    .item_tag  (item_tag),
    .item_type (item_type),
    .cmd       (cmd),
    .stat      (stat),
    .status    (status),
    .taken_tag (taken_tag),
    .occupancy (occupancy)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= CNT_BITS'(DEPTH))
    else $error("entry count above depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous one still executing");

  a_tag_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_DONE) |-> taken_tag == '0)
    else $error("nonzero tag on failed request");

  a_full_occupancy: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> occupancy == CNT_BITS'(DEPTH))
    else $error("full status with queue not full");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |=> stat.count == $past(stat.count) - CNT_BITS'(1))
    else $error("take did not drop the entry count by one");

endmodule
